FILE: rtl/pul_pkg.sv
// ----------------------------------------------------------------------------
// pul_pkg
// Types, register indexes and fixed-point helpers for the pinhole undistort lift.
// ----------------------------------------------------------------------------
package pul_pkg;

    localparam int ITERATIONS_DEF = 8;

    localparam logic [2:0] REG_INV_FX = 3'd0;
    localparam logic [2:0] REG_OFF_X  = 3'd1;
    localparam logic [2:0] REG_INV_FY = 3'd2;
    localparam logic [2:0] REG_OFF_Y  = 3'd3;
    localparam logic [2:0] REG_K1     = 3'd4;
    localparam logic [2:0] REG_K2     = 3'd5;
    localparam logic [2:0] REG_P1     = 3'd6;
    localparam logic [2:0] REG_P2     = 3'd7;

    localparam logic [46:0] INV_F_RESET = 47'd17592186044416;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] ray_x;
        logic signed [31:0] ray_y;
    } t_out;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_coef;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

    // floor(a*b / 2^28), saturated
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [35:0] s;
        p = a * b;
        s = p[63:28];
        if (s > 36'sd2147483647)       return 32'sh7FFFFFFF;
        else if (s < -36'sd2147483648) return 32'sh80000000;
        else                           return s[31:0];
    endfunction

endpackage

FILE: rtl/pul_iter.sv
// ----------------------------------------------------------------------------
// pul_iter
// One undistortion step u = d - dist(u), spread over four register stages.
// ----------------------------------------------------------------------------
module pul_iter
    import pul_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_coef              i_coef,
    input  logic signed [31:0] i_dx,
    input  logic signed [31:0] i_dy,
    input  logic signed [31:0] i_ux,
    input  logic signed [31:0] i_uy,
    output logic               o_valid,
    output logic signed [31:0] o_dx,
    output logic signed [31:0] o_dy,
    output logic signed [31:0] o_ux,
    output logic signed [31:0] o_uy
);

    logic [3:0] r_v;
    logic signed [31:0] r_dx [4];
    logic signed [31:0] r_dy [4];
    // stage 1
    logic signed [31:0] r1_x, r1_y, r1_x2, r1_y2, r1_xy;
    // stage 2
    logic signed [31:0] r2_x, r2_y, r2_r2, r2_k1r, r2_k2r, r2_pxy1, r2_pxy2, r2_x2, r2_y2;
    // stage 3
    logic signed [31:0] r3_x, r3_y, r3_rad, r3_pxy1, r3_pxy2, r3_tx, r3_ty;
    // stage 4
    logic signed [31:0] r4_ux, r4_uy;

    logic signed [31:0] n_r2, n_rad, n_tx, n_ty, n_distx, n_disty;

    always_comb begin
        n_r2 = sat34(34'(r1_x2) + 34'(r1_y2));
    end

    always_comb begin
        n_rad = sat34(34'(r2_k1r) + 34'(mulq(r2_k2r, r2_r2)));
        n_tx  = sat34(34'(r2_r2) + (34'(r2_x2) <<< 1));
        n_ty  = sat34(34'(r2_r2) + (34'(r2_y2) <<< 1));
    end

    always_comb begin
        n_distx = sat34(34'(mulq(r3_x, r3_rad)) + (34'(r3_pxy1) <<< 1)
                        + 34'(mulq(i_coef.p2, r3_tx)));
        n_disty = sat34(34'(mulq(r3_y, r3_rad)) + (34'(r3_pxy2) <<< 1)
                        + 34'(mulq(i_coef.p1, r3_ty)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx[0] <= i_dx;  r_dy[0] <= i_dy;
            for (int k = 1; k < 4; k++) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
            end
            r1_x  <= i_ux;  r1_y <= i_uy;
            r1_x2 <= mulq(i_ux, i_ux);
            r1_y2 <= mulq(i_uy, i_uy);
            r1_xy <= mulq(i_ux, i_uy);
            r2_x  <= r1_x;  r2_y <= r1_y;
            r2_r2 <= n_r2;
            r2_k1r <= mulq(i_coef.k1, n_r2);
            r2_k2r <= mulq(i_coef.k2, n_r2);
            r2_pxy1 <= mulq(i_coef.p1, r1_xy);
            r2_pxy2 <= mulq(i_coef.p2, r1_xy);
            r2_x2 <= r1_x2; r2_y2 <= r1_y2;
            r3_x <= r2_x; r3_y <= r2_y;
            r3_rad <= n_rad;
            r3_pxy1 <= r2_pxy1; r3_pxy2 <= r2_pxy2;
            r3_tx <= n_tx; r3_ty <= n_ty;
            r4_ux <= sat34(34'(r_dx[2]) - 34'(n_distx));
            r4_uy <= sat34(34'(r_dy[2]) - 34'(n_disty));
        end
    end

    assign o_valid = r_v[3];
    assign o_dx = r_dx[3];
    assign o_dy = r_dy[3];
    assign o_ux = r4_ux;
    assign o_uy = r4_uy;

endmodule

FILE: rtl/pinhole_undistort_lift.sv
// ----------------------------------------------------------------------------
// pinhole_undistort_lift
// Path from request accept: normalise stages, one step per iteration, then the result register.
// Throughput: one request per cycle while o_stall is low; one four-stage pipelined step per iteration.
// A stalled output keeps one result in a skid slot; a full slot freezes the pipeline.
// Reset: synchronous, active low; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module pinhole_undistort_lift
    import pul_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [46:0]        r_inv_fx, r_inv_fy;
    logic signed [47:0] r_off_x, r_off_y;
    t_coef              r_coef;
    logic [2:0]         w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_fx <= INV_F_RESET; r_inv_fy <= INV_F_RESET;
            r_off_x <= '0; r_off_y <= '0; r_coef <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_INV_FX: r_inv_fx <= pwdata[46:0];
                REG_OFF_X:  r_off_x  <= pwdata[47:0];
                REG_INV_FY: r_inv_fy <= pwdata[46:0];
                REG_OFF_Y:  r_off_y  <= pwdata[47:0];
                REG_K1:     r_coef.k1 <= pwdata[31:0];
                REG_K2:     r_coef.k2 <= pwdata[31:0];
                REG_P1:     r_coef.p1 <= pwdata[31:0];
                REG_P2:     r_coef.p2 <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_INV_FX: prdata = {17'd0, r_inv_fx};
            REG_OFF_X:  prdata = {{16{r_off_x[47]}}, r_off_x};
            REG_INV_FY: prdata = {17'd0, r_inv_fy};
            REG_OFF_Y:  prdata = {{16{r_off_y[47]}}, r_off_y};
            REG_K1:     prdata = {{32{r_coef.k1[31]}}, r_coef.k1};
            REG_K2:     prdata = {{32{r_coef.k2[31]}}, r_coef.k2};
            REG_P1:     prdata = {{32{r_coef.p1[31]}}, r_coef.p1};
            REG_P2:     prdata = {{32{r_coef.p2[31]}}, r_coef.p2};
            default:    prdata = '0;
        endcase
    end

    // output register plus skid slot
    logic r_ov, r_sv;
    t_out r_od, r_sd;
    logic en;
    assign en = !r_sv;
    assign o_stall = r_sv;

    // normalise: stage A multiply, stage B add, stage C saturate
    logic [62:0]        r_pa_x, r_pa_y;
    logic signed [47:0] r_oa_x, r_oa_y;
    logic signed [64:0] r_sb_x, r_sb_y;
    logic signed [31:0] r_nc_x, r_nc_y;
    logic [2:0]         r_nv;

    function automatic logic signed [31:0] sat_norm(input logic signed [64:0] v);
        logic signed [44:0] s;
        s = v[64:20];
        if (s > 45'sd2147483647)       return 32'sh7FFFFFFF;
        else if (s < -45'sd2147483648) return 32'sh80000000;
        else                           return s[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_nv <= '0;
        else if (en)  r_nv <= {r_nv[1:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa_x <= r_inv_fx * i_data.pixel_x;
            r_pa_y <= r_inv_fy * i_data.pixel_y;
            r_oa_x <= r_off_x;  r_oa_y <= r_off_y;
            r_sb_x <= $signed({2'b00, r_pa_x}) + ($signed(65'(r_oa_x)) <<< 4);
            r_sb_y <= $signed({2'b00, r_pa_y}) + ($signed(65'(r_oa_y)) <<< 4);
            r_nc_x <= sat_norm(r_sb_x);
            r_nc_y <= sat_norm(r_sb_y);
        end
    end

    logic               s_v  [ITERATIONS+1];
    logic signed [31:0] s_dx [ITERATIONS+1];
    logic signed [31:0] s_dy [ITERATIONS+1];
    logic signed [31:0] s_ux [ITERATIONS+1];
    logic signed [31:0] s_uy [ITERATIONS+1];

    assign s_v[0] = r_nv[2];
    assign s_dx[0] = r_nc_x; assign s_dy[0] = r_nc_y;
    assign s_ux[0] = r_nc_x; assign s_uy[0] = r_nc_y;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_it
        pul_iter u_it (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s_v[g]),
            .i_coef(r_coef), .i_dx(s_dx[g]), .i_dy(s_dy[g]),
            .i_ux(s_ux[g]), .i_uy(s_uy[g]),
            .o_valid(s_v[g+1]), .o_dx(s_dx[g+1]), .o_dy(s_dy[g+1]),
            .o_ux(s_ux[g+1]), .o_uy(s_uy[g+1])
        );
    end

    t_out w_res;
    assign w_res.ray_x = s_ux[ITERATIONS];
    assign w_res.ray_y = s_uy[ITERATIONS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_sv <= 1'b0;
        end else begin
            if (r_sv) begin
                if (!i_stall) begin
                    r_od <= r_sd; r_ov <= 1'b1; r_sv <= 1'b0;
                end
            end else if (r_ov && i_stall) begin
                if (s_v[ITERATIONS]) begin
                    r_sd <= w_res; r_sv <= 1'b1;
                end
            end else begin
                r_ov <= s_v[ITERATIONS];
                r_od <= w_res;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

    a_skid_only_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && i_stall))
        else $error("skid filled without output stall");
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid full with empty output");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

endmodule
